// ===== sv/crs_pkg.sv =====
`timescale 1ns / 1ps
package crs_pkg;

   // Store geometry and edge width
   localparam int MAX_RECTS  = 32;
   localparam int COORD_BITS = 16;
   localparam int IDX_W      = $clog2(MAX_RECTS);
   localparam int CNT_W      = $clog2(MAX_RECTS + 1);
   localparam int ADDR_W     = IDX_W + 1;
   localparam int RECT_W     = 4 * COORD_BITS;
   localparam int DEPTH      = 2 * MAX_RECTS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COORD_BITS:0]   coord_x_type;

   typedef struct packed {
      coord_type l;
      coord_type t;
      coord_type r;
      coord_type b;
   } rect_type;

   typedef enum logic [1:0] {
      FUNC_ADD     = 2'd0,
      FUNC_EXCLUDE = 2'd1,
      FUNC_CLEAR   = 2'd2,
      FUNC_READ    = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_X_RD,
      S_X_PIECE,
      S_RESP,
      S_R_RD,
      S_R_OUT
   } state_type;

   // Result of one pass of the piece unit
   typedef struct packed {
      logic     hit;
      logic     ok;
      rect_type box;
   } piece_result_type;

endpackage

// ===== sv/crs_ram.sv =====
`timescale 1ns / 1ps
module crs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port, one registered read port; read data holds between reads
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

// ===== sv/crs_piece.sv =====
`timescale 1ns / 1ps
module crs_piece
   import crs_pkg::*;
(
   input  rect_type         cur,
   input  rect_type         given,
   input  logic [1:0]       sel,
   output piece_result_type res
);

   coord_x_type cl, ct, cr, cb, gl, gt, gr, gb;
   coord_x_type hl, ht, hr, hb;
   coord_x_type pl, pt, pr, pb;

   always_comb begin
      cl = coord_x_type'(cur.l);
      ct = coord_x_type'(cur.t);
      cr = coord_x_type'(cur.r);
      cb = coord_x_type'(cur.b);
      gl = coord_x_type'(given.l);
      gt = coord_x_type'(given.t);
      gr = coord_x_type'(given.r);
      gb = coord_x_type'(given.b);

      // Overlap of stored and given rectangle
      hl = (cl > gl) ? cl : gl;
      ht = (ct > gt) ? ct : gt;
      hr = (cr < gr) ? cr : gr;
      hb = (cb < gb) ? cb : gb;
      res.hit = (hl <= hr) && (ht <= hb);

      // Selected piece: above, below, left, right
      unique case (sel)
         2'd0: begin
            pl = cl; pt = ct; pr = cr; pb = ht - coord_x_type'(1);
         end
         2'd1: begin
            pl = cl; pt = hb + coord_x_type'(1); pr = cr; pb = cb;
         end
         2'd2: begin
            pl = cl; pt = ct; pr = hl - coord_x_type'(1); pb = hb;
         end
         default: begin
            pl = hr + coord_x_type'(1); pt = ht; pr = cr; pb = cb;
         end
      endcase
      res.ok    = (pl <= pr) && (pt <= pb);
      res.box.l = coord_type'(pl);
      res.box.t = coord_type'(pt);
      res.box.r = coord_type'(pr);
      res.box.b = coord_type'(pb);
   end

endmodule

// ===== sv/clip_region_rect_subtract.sv =====
`timescale 1ns / 1ps
// Clip region held as a list of up to 32 inclusive rectangles.
// Input channel req_*: tuser carries the operation (add, exclude, clear,
// read), tdata the given rectangle. One transfer is taken at a time;
// req_tready is high only while the block is idle.
// Result channel rsp_*: add, exclude and clear give one result with the
// status and the new count. Read gives one result per stored rectangle,
// head first, tlast on the final one; an empty region gives one result
// with tuser has_rect clear.
// Add and clear answer in the cycle after the transfer. Exclude reads each
// stored rectangle from the store, then handles its pieces, up to four, one
// at a time through the shared piece unit.
// Read fetches each rectangle through the single store read port.
// Reset empties the list and selects bank 0; the store needs no clearing.
// When the receiver stalls, the pending result holds and nothing advances.
module clip_region_rect_subtract
   import crs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // rect_left, rect_top, rect_right, rect_bottom
   input  logic [1:0]  req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // out_left, out_top, out_right, out_bottom, count, pad
   output logic [1:0]  rsp_tuser,  // has_rect, status
   output logic        rsp_tlast
);

   state_type        state_ff, state_in;
   logic             bank_ff, bank_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] nn_ff, nn_in;
   logic [1:0]       k_ff, k_in;
   logic             st_ff, st_in;
   rect_type         given_ff, given_in;

   logic              we, re;
   logic [ADDR_W-1:0] waddr, raddr;
   rect_type          wdata, rdata;
   piece_result_type  piece;
   rect_type          req_rect;
   func_type          req_func;
   logic              req_xfer;

   assign req_func   = func_type'(req_tuser);
   assign req_rect.l = req_tdata[0  +: COORD_BITS];
   assign req_rect.t = req_tdata[16 +: COORD_BITS];
   assign req_rect.r = req_tdata[32 +: COORD_BITS];
   assign req_rect.b = req_tdata[48 +: COORD_BITS];
   assign req_xfer   = req_tvalid && req_tready;

   crs_ram #(.WIDTH(RECT_W), .DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   crs_piece u_piece (
      .cur   (rdata),
      .given (given_ff),
      .sel   (k_ff),
      .res   (piece)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bank_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         bank_ff  <= bank_in;
         count_ff <= count_in;
      end
      idx_ff   <= idx_in;
      nn_ff    <= nn_in;
      k_ff     <= k_in;
      st_ff    <= st_in;
      given_ff <= given_in;
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      bank_in    = bank_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      nn_in      = nn_ff;
      k_in       = k_ff;
      st_in      = st_ff;
      given_in   = given_ff;
      we         = 1'b0;
      waddr      = {bank_ff, count_ff[IDX_W-1:0]};
      wdata      = req_rect;
      re         = 1'b0;
      raddr      = {bank_ff, idx_ff[IDX_W-1:0] - 1'b1};
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_tlast  = 1'b0;
      rsp_tuser  = {st_ff, 1'b0};
      rsp_tdata  = {2'b00, 6'(count_ff), 64'd0};

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_xfer) begin
               given_in = req_rect;
               st_in    = 1'b0;
               idx_in   = count_ff;
               nn_in    = '0;
               k_in     = 2'd0;
               unique case (req_func)
                  FUNC_ADD: begin
                     state_in = S_RESP;
                     if (count_ff >= CNT_W'(MAX_RECTS)) begin
                        st_in = 1'b1;
                     end else begin
                        we       = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  FUNC_EXCLUDE: state_in = S_X_RD;
                  FUNC_CLEAR: begin
                     count_in = '0;
                     state_in = S_RESP;
                  end
                  default: state_in = (count_ff == '0) ? S_RESP : S_R_RD;
               endcase
            end
         end
         S_X_RD: begin
            if (idx_ff == '0) begin
               bank_in  = ~bank_ff;
               count_in = nn_ff;
               state_in = S_RESP;
            end else begin
               re       = 1'b1;
               idx_in   = idx_ff - 1'b1;
               k_in     = 2'd0;
               state_in = S_X_PIECE;
            end
         end
         S_X_PIECE: begin
            // Keep the whole rectangle or push the selected piece
            waddr = {~bank_ff, nn_ff[IDX_W-1:0]};
            wdata = piece.hit ? piece.box : rdata;
            if (!piece.hit || piece.ok) begin
               if (nn_ff >= CNT_W'(MAX_RECTS)) begin
                  st_in = 1'b1;
               end else begin
                  we    = 1'b1;
                  nn_in = nn_ff + 1'b1;
               end
            end
            if (!piece.hit || k_ff == 2'd3) begin
               state_in = S_X_RD;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_RESP: begin
            rsp_tvalid = 1'b1;
            rsp_tlast  = 1'b1;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         S_R_RD: begin
            re       = 1'b1;
            idx_in   = idx_ff - 1'b1;
            state_in = S_R_OUT;
         end
         default: begin
            // S_R_OUT: stored rectangle straight from the store read register
            rsp_tvalid = 1'b1;
            rsp_tlast  = (idx_ff == '0);
            rsp_tuser  = 2'b01;
            rsp_tdata  = {2'b00, 6'(count_ff), 16'($signed(rdata.b)),
                          16'($signed(rdata.r)), 16'($signed(rdata.t)),
                          16'($signed(rdata.l))};
            if (rsp_tready) begin
               state_in = (idx_ff == '0) ? S_IDLE : S_R_RD;
            end
         end
      endcase
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RECTS))
      else $error("region count above capacity");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("input taken while an operation is in progress");

   a_last_ends_op: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> state_ff == S_IDLE)
      else $error("final result did not return to idle");

   a_bank_flip: assert property (@(posedge clock) disable iff (reset)
      bank_ff != $past(bank_ff) |-> $past(state_ff) == S_X_RD)
      else $error("bank switched outside the end of exclude");

endmodule

// ===== sim/tb_clip_region_rect_subtract.sv =====
`timescale 1ns / 1ps
module tb_clip_region_rect_subtract;
   import crs_pkg::*;

   typedef struct {
      rect_type box;
      logic     has_rect;
      logic     status;
      logic [5:0] count;
      logic     last;
   } region_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // rect_left, rect_top, rect_right, rect_bottom
   logic [1:0]  req_tuser = '0;   // func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // out_left, out_top, out_right, out_bottom, count, pad
   logic [1:0]  rsp_tuser;        // has_rect, status
   logic        rsp_tlast;

   // Shadow copy of the region, head at the highest index
   rect_type          region_q[$];
   region_result_type expected_q[$];
   int unsigned       fail_cnt = 0;
   int unsigned       cycle_cnt = 0;
   logic              rx_paused = 1'b0;
   int                rx_wait = 0;

   clip_region_rect_subtract i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #2 clock = ~clock;

   function automatic logic rect_valid(rect_type a);
      return a.l <= a.r && a.t <= a.b;
   endfunction

   function automatic rect_type mk_rect(int l, int t, int r, int b);
      rect_type x;
      x.l = coord_type'(l); x.t = coord_type'(t);
      x.r = coord_type'(r); x.b = coord_type'(b);
      return x;
   endfunction

   function automatic void push_expect(rect_type bx, logic hr, logic st, int cnt, logic lst);
      region_result_type e;
      e.box = hr ? bx : '0;
      e.has_rect = hr;
      e.status = st;
      e.count = 6'(cnt);
      e.last = lst;
      expected_q.push_back(e);
   endfunction

   // Apply one operation to the shadow region and queue its results
   function automatic void predict_region(func_type f, rect_type g);
      rect_type nl[$];
      rect_type c, h;
      rect_type p[4];
      logic st;
      int n;
      st = 1'b0;
      case (f)
         FUNC_ADD: begin
            if (region_q.size() >= MAX_RECTS) st = 1'b1;
            else region_q.push_back(g);
            push_expect('0, 1'b0, st, region_q.size(), 1'b1);
         end
         FUNC_EXCLUDE: begin
            for (int i = region_q.size() - 1; i >= 0; i--) begin
               c = region_q[i];
               h.l = (c.l > g.l) ? c.l : g.l;
               h.t = (c.t > g.t) ? c.t : g.t;
               h.r = (c.r < g.r) ? c.r : g.r;
               h.b = (c.b < g.b) ? c.b : g.b;
               if (!rect_valid(h)) begin
                  if (nl.size() >= MAX_RECTS) st = 1'b1;
                  else nl.push_back(c);
               end else begin
                  // int arithmetic: edge +-1 may leave the 16-bit range
                  p[0] = mk_rect(c.l, c.t, c.r, int'(h.t) - 1);
                  p[1] = mk_rect(c.l, int'(h.b) + 1, c.r, c.b);
                  p[2] = mk_rect(c.l, c.t, int'(h.l) - 1, h.b);
                  p[3] = mk_rect(int'(h.r) + 1, h.t, c.r, c.b);
                  if (int'(c.t) <= int'(h.t) - 1)
                     if (nl.size() >= MAX_RECTS) st = 1'b1; else nl.push_back(p[0]);
                  if (int'(h.b) + 1 <= int'(c.b))
                     if (nl.size() >= MAX_RECTS) st = 1'b1; else nl.push_back(p[1]);
                  if (int'(c.l) <= int'(h.l) - 1 && h.t <= h.b)
                     if (nl.size() >= MAX_RECTS) st = 1'b1; else nl.push_back(p[2]);
                  if (int'(h.r) + 1 <= int'(c.r) && h.t <= c.b)
                     if (nl.size() >= MAX_RECTS) st = 1'b1; else nl.push_back(p[3]);
               end
            end
            region_q = nl;
            push_expect('0, 1'b0, st, region_q.size(), 1'b1);
         end
         FUNC_CLEAR: begin
            region_q.delete();
            push_expect('0, 1'b0, 1'b0, 0, 1'b1);
         end
         default: begin
            n = region_q.size();
            if (n == 0) push_expect('0, 1'b0, 1'b0, 0, 1'b1);
            for (int k = 0; k < n; k++)
               push_expect(region_q[n-1-k], 1'b1, 1'b0, n, k == n - 1);
         end
      endcase
   endfunction

   // Send one operation after a random gap; valid drops only during a gap
   task automatic send_op(func_type f, rect_type g, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 13);
      if (gap != 0) req_tvalid <= 1'b0;
      repeat (gap) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {g.b, g.r, g.t, g.l};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_region(f, g);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic rect_type rand_rect(int span);
      int l, t;
      l = $urandom_range(0, 2 * span) - span;
      t = $urandom_range(0, 2 * span) - span;
      return mk_rect(l, t, l + $urandom_range(0, span), t + $urandom_range(0, span));
   endfunction

   function automatic rect_type any_rect();
      return rect_type'({$urandom, $urandom});
   endfunction

   // Receiver stall pattern: a fresh random wait after each transfer, the longest one while paused
   always @(posedge clock) begin
      int w;
      cycle_cnt <= cycle_cnt + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_wait    <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         w = rx_paused ? 13 : $urandom_range(0, 13);
         rx_wait    <= w;
         rsp_tready <= (w == 0);
      end else if (rx_wait > 1) begin
         rx_wait <= rx_wait - 1;
      end else begin
         rx_wait    <= 0;
         rsp_tready <= 1'b1;
      end
   end

   // Result checker
   always @(posedge clock) begin
      region_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result %h", rsp_tdata);
            fail_cnt++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_tdata[15:0] !== e.box.l) begin
               $error("out_left exp %h got %h", e.box.l, rsp_tdata[15:0]); fail_cnt++;
            end
            if (rsp_tdata[31:16] !== e.box.t) begin
               $error("out_top exp %h got %h", e.box.t, rsp_tdata[31:16]); fail_cnt++;
            end
            if (rsp_tdata[47:32] !== e.box.r) begin
               $error("out_right exp %h got %h", e.box.r, rsp_tdata[47:32]); fail_cnt++;
            end
            if (rsp_tdata[63:48] !== e.box.b) begin
               $error("out_bottom exp %h got %h", e.box.b, rsp_tdata[63:48]); fail_cnt++;
            end
            if (rsp_tdata[69:64] !== e.count) begin
               $error("count exp %0d got %0d", e.count, rsp_tdata[69:64]); fail_cnt++;
            end
            if (rsp_tuser[0] !== e.has_rect) begin
               $error("has_rect exp %b got %b", e.has_rect, rsp_tuser[0]); fail_cnt++;
            end
            if (rsp_tuser[1] !== e.status) begin
               $error("status exp %b got %b", e.status, rsp_tuser[1]); fail_cnt++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last exp %b got %b", e.last, rsp_tlast); fail_cnt++;
            end
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      if (cycle_cnt > 1500000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic test_directed();
      send_op(FUNC_READ, '0);
      send_op(FUNC_ADD, mk_rect(-32768, -32768, 32767, 32767));
      send_op(FUNC_ADD, mk_rect(10, 10, 5, 20));
      send_op(FUNC_ADD, mk_rect(0, 0, 9, 9));
      send_op(FUNC_READ, '0);
      send_op(FUNC_EXCLUDE, mk_rect(3, 3, 5, 5));
      send_op(FUNC_READ, '0);
      send_op(FUNC_EXCLUDE, mk_rect(-32768, -32768, 32767, 32767));
      send_op(FUNC_READ, '0);
      send_op(FUNC_ADD, mk_rect(-32768, -32768, 32767, 32767));
      send_op(FUNC_EXCLUDE, mk_rect(32767, 32767, 32767, 32767));
      send_op(FUNC_EXCLUDE, mk_rect(-32768, -32768, -32768, -32768));
      send_op(FUNC_READ, '0);
      send_op(FUNC_CLEAR, any_rect());
      send_op(FUNC_READ, '0);
   endtask

   // Fill to the limit, push one more, then split everything to overflow
   task automatic test_full();
      send_op(FUNC_CLEAR, '0);
      for (int i = 0; i < MAX_RECTS; i++)
         send_op(FUNC_ADD, mk_rect(i * 10, 0, i * 10 + 8, 8), 1);
      send_op(FUNC_ADD, mk_rect(1, 1, 2, 2));
      send_op(FUNC_EXCLUDE, mk_rect(-1000, 3, 1000, 4));
      send_op(FUNC_READ, '0);
      wait_drained();
   endtask

   task automatic test_random();
      int sel;
      for (int i = 0; i < 270; i++) begin
         sel = $urandom_range(0, 99);
         rx_paused = (i >= 100 && i < 130);
         if (i == 200) wait_drained();
         if (sel < 35) send_op(FUNC_ADD, ($urandom_range(0, 9) == 0) ? any_rect() : rand_rect(40));
         else if (sel < 65) send_op(FUNC_EXCLUDE,
                                    ($urandom_range(0, 9) == 0) ? any_rect() : rand_rect(40));
         else if (sel < 70) send_op(FUNC_CLEAR, any_rect());
         else send_op(FUNC_READ, any_rect());
      end
      rx_paused = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full();
      test_random();
      wait_drained();
      if (fail_cnt == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

// ===== files.f =====
sv/crs_pkg.sv
sv/crs_ram.sv
sv/crs_piece.sv
sv/clip_region_rect_subtract.sv
sim/tb_clip_region_rect_subtract.sv
